### hdl/lsfh_pkg.sv
package lsfh_pkg;

  // Default for the largest frame the data store is built for.
  localparam int MAX_DATA_BYTES_DEF = 8;

  // Depth of the event queue between the front and the back part.
  localparam int QUEUE_DEPTH = 2;

  // Protocol constants.
  localparam logic [7:0] SYNC_BYTE     = 8'h55;
  localparam logic [7:0] CLASSIC_PID_A = 8'h3C;
  localparam logic [7:0] CLASSIC_PID_B = 8'h7D;

  // Event codes as they arrive on the input stream.
  localparam logic [1:0] REQ_BREAK  = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_TXDONE = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // Frame status codes reported with each result word.
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_RXOK    = 3'd1;
  localparam logic [2:0] ST_RXBAD   = 3'd2;
  localparam logic [2:0] ST_SENT    = 3'd3;
  localparam logic [2:0] ST_ERR     = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PID_RECEIVE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PID_RESPOND   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESPONSE_DATA = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DATA_LENGTH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_TICKS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_CHECK    = 3'd5;

  typedef enum logic [1:0] {
    EV_BREAK,
    EV_BYTE,
    EV_TXDONE,
    EV_TICK
  } ev_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_PID,
    PH_RXDATA,
    PH_RXCHECK,
    PH_TXDATA,
    PH_TXCHECK
  } phase_t;

  typedef struct packed {
    logic [7:0]  pid_receive;
    logic [7:0]  pid_respond;
    logic [63:0] response_data;
    logic [3:0]  data_length;
    logic [7:0]  timeout_ticks;
    logic        sync_check;
  } cfg_t;

  // One classified event handed from the front to the back part.
  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] rx;
    logic       is_sync;
    logic       match_respond;
    logic       match_receive;
    logic       classic;
  } ev_t;

  // End-around 8-bit add: a carry out is folded back into bit zero.
  function automatic logic [7:0] add_ea(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

endpackage

### hdl/lsfh_front.sv
module lsfh_front (
  input  logic            clk,
  input  logic            rst,
  input  lsfh_pkg::cfg_t  cfg,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // rx_byte
  input  logic [1:0]      s_tuser,   // req_type
  output logic            ev_valid,
  input  logic            ev_ready,
  output lsfh_pkg::ev_t   ev
);
  import lsfh_pkg::*;

  ev_t ev_c;

  // Decode the event kind and precompute byte compares for the back part.
  always_comb begin
    ev_c.rx            = s_tdata;
    ev_c.is_sync       = (s_tdata == SYNC_BYTE);
    ev_c.match_respond = (s_tdata == cfg.pid_respond);
    ev_c.match_receive = (s_tdata == cfg.pid_receive);
    ev_c.classic       = (s_tdata == CLASSIC_PID_A) || (s_tdata == CLASSIC_PID_B);
    unique case (s_tuser)
      REQ_BREAK:  ev_c.kind = EV_BREAK;
      REQ_BYTE:   ev_c.kind = EV_BYTE;
      REQ_TXDONE: ev_c.kind = EV_TXDONE;
      default:    ev_c.kind = EV_TICK;
    endcase
  end

  // The register stage takes a new word whenever it is empty or drains.
  assign s_tready = !ev_valid || ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s_tready) begin
      ev_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ev <= ev_c;
    end
  end

endmodule

### hdl/lsfh_queue.sv
module lsfh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  lsfh_pkg::ev_t  wr_ev,
  output logic           rd_valid,
  input  logic           rd_ready,
  output lsfh_pkg::ev_t  rd_ev
);
  import lsfh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ev_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_ev    = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers wrap at the queue depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ev;
    end
  end

endmodule

### hdl/lsfh_back.sv
module lsfh_back #(
  parameter int MAX_DATA_BYTES = lsfh_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  lsfh_pkg::cfg_t  cfg,
  input  logic            ev_valid,
  output logic            ev_ready,
  input  lsfh_pkg::ev_t   ev,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [79:0]     m_tdata,   // tx_byte, frame_pid, frame_data
  output logic [3:0]      m_tuser    // tx_valid, frame_status
);
  import lsfh_pkg::*;

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  byte_index;
  logic [3:0]  byte_index_next;
  logic [7:0]  frame_id;
  logic [7:0]  frame_id_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [7:0]  idle_counter;
  logic [7:0]  idle_counter_next;
  logic [7:0]  data_store [MAX_DATA_BYTES];

  logic        pop;
  logic [3:0]  len;
  logic [7:0]  resp_byte;
  logic [7:0]  cnt_dec;
  logic [3:0]  index_inc;
  logic        store_we;
  logic        txv;
  logic [7:0]  txb;
  logic [2:0]  status;
  logic [63:0] fdata;
  logic [7:0]  resp_part [8];
  logic [7:0]  pair_sum [4];
  logic [7:0]  quad_sum [2];
  logic [7:0]  resp_total;

  // An event is taken whenever the output register is free or drains.
  assign ev_ready = !m_tvalid || m_tready;
  assign pop      = ev_valid && ev_ready;

  // Effective frame length: zero counts as one, clamped to the store size.
  always_comb begin
    if (cfg.data_length == 4'd0) begin
      len = 4'd1;
    end else if (cfg.data_length > 4'(MAX_DATA_BYTES)) begin
      len = 4'(MAX_DATA_BYTES);
    end else begin
      len = cfg.data_length;
    end
  end

  assign resp_byte = cfg.response_data[{byte_index[2:0], 3'b000} +: 8];
  assign cnt_dec   = (idle_counter != 8'd0) ? idle_counter - 8'd1 : 8'd0;
  assign index_inc = byte_index + 4'd1;

  // End-around sum of the response bytes of one frame, built as a tree.
  // Bytes beyond the frame length enter as zero, which leaves the sum alone.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      resp_part[i] = (4'(i) < len) ? cfg.response_data[i*8 +: 8] : 8'd0;
    end
    for (int i = 0; i < 4; i++) begin
      pair_sum[i] = add_ea(resp_part[2*i], resp_part[2*i+1]);
    end
    quad_sum[0] = add_ea(pair_sum[0], pair_sum[1]);
    quad_sum[1] = add_ea(pair_sum[2], pair_sum[3]);
    resp_total  = add_ea(quad_sum[0], quad_sum[1]);
  end

  // Frame sequencer: next state and result word for the event at the head.
  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    frame_id_next     = frame_id;
    running_sum_next  = running_sum;
    idle_counter_next = idle_counter;
    store_we          = 1'b0;
    txv               = 1'b0;
    txb               = 8'd0;
    status            = ST_NONE;
    fdata             = 64'd0;
    if (pop) begin
      unique case (ev.kind)
        EV_BREAK: begin
          phase_next        = cfg.sync_check ? PH_SYNC : PH_PID;
          frame_id_next     = 8'd0;
          byte_index_next   = 4'd0;
          idle_counter_next = cfg.timeout_ticks;
        end
        EV_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_SYNC: begin
              if (ev.is_sync) begin
                phase_next        = PH_PID;
                idle_counter_next = cfg.timeout_ticks;
              end else begin
                status = ST_ERR;
              end
            end
            PH_PID: begin
              idle_counter_next = cfg.timeout_ticks;
              frame_id_next     = ev.rx;
              if (ev.match_respond) begin
                // The checksum covers the whole response, fixed at the PID.
                running_sum_next = add_ea(ev.classic ? 8'd0 : ev.rx, resp_total);
                txv              = 1'b1;
                txb              = cfg.response_data[7:0];
                byte_index_next  = 4'd1;
                phase_next       = (len <= 4'd1) ? PH_TXCHECK : PH_TXDATA;
              end else if (ev.match_receive) begin
                running_sum_next = ev.classic ? 8'd0 : ev.rx;
                byte_index_next  = 4'd0;
                phase_next       = PH_RXDATA;
              end else begin
                status = ST_ERR;
              end
            end
            PH_RXDATA: begin
              idle_counter_next = cfg.timeout_ticks;
              store_we          = 1'b1;
              running_sum_next  = add_ea(running_sum, ev.rx);
              byte_index_next   = index_inc;
              if (index_inc >= len) begin
                phase_next = PH_RXCHECK;
              end
            end
            PH_RXCHECK: begin
              idle_counter_next = cfg.timeout_ticks;
              for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                if (4'(i) < len) begin
                  fdata[i*8 +: 8] = data_store[i];
                end
              end
              status = (ev.rx == ~running_sum) ? ST_RXOK : ST_RXBAD;
            end
            default: begin
              status = ST_ERR;
            end
          endcase
        end
        EV_TXDONE: begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_TXDATA: begin
              idle_counter_next = cfg.timeout_ticks;
              txv               = 1'b1;
              txb               = resp_byte;
              byte_index_next   = index_inc;
              if (index_inc >= len) begin
                phase_next = PH_TXCHECK;
              end
            end
            PH_TXCHECK: begin
              idle_counter_next = cfg.timeout_ticks;
              txv               = 1'b1;
              txb               = ~running_sum;
              status            = ST_SENT;
            end
            default: begin
              status = ST_ERR;
            end
          endcase
        end
        default: begin
          idle_counter_next = cnt_dec;
          if (phase != PH_IDLE && cnt_dec == 8'd0) begin
            status = ST_TIMEOUT;
          end
        end
      endcase
      // Any report ends the frame.
      if (status != ST_NONE) begin
        phase_next      = PH_IDLE;
        byte_index_next = 4'd0;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= 4'd0;
      frame_id     <= 8'd0;
      running_sum  <= 8'd0;
      idle_counter <= 8'd0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      frame_id     <= frame_id_next;
      running_sum  <= running_sum_next;
      idle_counter <= idle_counter_next;
    end
  end

  // Received data bytes; only entries written in the current frame are read.
  always_ff @(posedge clk) begin
    if (store_we) begin
      data_store[byte_index[IDX_W-1:0]] <= ev.rx;
    end
  end

  // Output register decouples the sequencer from the result consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ev_ready) begin
      m_tvalid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {fdata, (txv || status != ST_NONE) ? frame_id_next : 8'd0, txb};
      m_tuser <= {status, txv};
    end
  end

  // The byte index never runs past the configured store size.
  assert property (@(posedge clk) disable iff (rst)
    byte_index <= 4'(MAX_DATA_BYTES))
    else $error("byte index beyond data store");

  // A break always opens a new header.
  assert property (@(posedge clk) disable iff (rst)
    (pop && ev.kind == EV_BREAK) |=> (phase == PH_SYNC || phase == PH_PID))
    else $error("break did not start a header");

  // Every report returns the sequencer to idle with a cleared index.
  assert property (@(posedge clk) disable iff (rst)
    (pop && status != ST_NONE) |=> (phase == PH_IDLE && byte_index == 4'd0))
    else $error("report did not end the frame");

  // Receive phases never drive a byte onto the bus.
  assert property (@(posedge clk) disable iff (rst)
    (pop && (phase == PH_RXDATA || phase == PH_RXCHECK || phase == PH_SYNC)) |-> !txv)
    else $error("transmit in a receive phase");

endmodule

### hdl/lin_slave_frame_handler_unit.sv
// LIN slave frame engine. Each input word is one bus event (break, received
// byte, transmit done or tick) and yields exactly one result word carrying
// the byte to send, if any, and the frame status with its PID and data. A
// new event word is accepted every clock cycle while the output side is not
// stalled; a word passes an input register stage, a two-entry event queue
// and the sequencer's output register before its result word is presented
// on the output. While the output side takes its results, the sequencer
// handles one event per cycle and sets the sustained rate. The user writes
// configuration through cfg_we, cfg_addr and cfg_wdata only while no word is
// in flight inside the block; the block itself does not enforce this.
module lin_slave_frame_handler_unit #(
  parameter int MAX_DATA_BYTES = lsfh_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsfh_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // rx_byte
  input  logic [1:0]                    s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [79:0]                   m_tdata,   // tx_byte, frame_pid, frame_data
  output logic [3:0]                    m_tuser    // tx_valid, frame_status
);
  import lsfh_pkg::*;

  cfg_t cfg;
  ev_t  fr_ev;
  ev_t  q_ev;
  logic fr_valid;
  logic fr_ready;
  logic q_valid;
  logic q_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pid_receive   <= 8'hF0;
      cfg.pid_respond   <= 8'hB1;
      cfg.response_data <= 64'h5F5E5D5C5B5A5958;
      cfg.data_length   <= 4'd8;
      cfg.timeout_ticks <= 8'd10;
      cfg.sync_check    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PID_RECEIVE:   cfg.pid_receive   <= cfg_wdata[7:0];
        CFG_PID_RESPOND:   cfg.pid_respond   <= cfg_wdata[7:0];
        CFG_RESPONSE_DATA: cfg.response_data <= cfg_wdata;
        CFG_DATA_LENGTH:   cfg.data_length   <= cfg_wdata[3:0];
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_wdata[7:0];
        CFG_SYNC_CHECK:    cfg.sync_check    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  lsfh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .ev_valid (fr_valid),
    .ev_ready (fr_ready),
    .ev       (fr_ev)
  );

  lsfh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_ev    (fr_ev),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_ev    (q_ev)
  );

  lsfh_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ev_valid (q_valid),
    .ev_ready (q_ready),
    .ev       (q_ev),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### test/lin_slave_frame_handler_unit_tb.sv
`timescale 1ns / 100ps

module lin_slave_frame_handler_unit_tb;
  import lsfh_pkg::*;

  // One result word, split into its fields.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [7:0]  pid;
    logic [63:0] data;
  } lin_result_t;

  // One directed event, with its result typed in where it is obvious.
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  rx;
    logic        typed;
    lin_result_t res;
  } stim_row_t;

  localparam lin_result_t NO_REPORT = '{1'b0, 8'h00, ST_NONE, 8'h00, 64'd0};

  // Directed events, run with the registers at their reset values.
  localparam stim_row_t STIM_ROWS [0:23] = '{
    '{REQ_BYTE,   8'h00, 1'b1, NO_REPORT},
    '{REQ_TXDONE, 8'hFF, 1'b1, NO_REPORT},
    '{REQ_TICK,   8'h00, 1'b1, NO_REPORT},
    '{REQ_BREAK,  8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'h12, 1'b1, '{1'b0, 8'h00, ST_ERR, 8'h12, 64'd0}},
    '{REQ_BREAK,  8'h00, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hB1, 1'b1, '{1'b1, 8'h58, ST_NONE, 8'hB1, 64'd0}},
    '{REQ_TXDONE, 8'h00, 1'b1, '{1'b1, 8'h59, ST_NONE, 8'hB1, 64'd0}},
    '{REQ_BYTE,   8'hFF, 1'b1, '{1'b0, 8'h00, ST_ERR, 8'hB1, 64'd0}},
    '{REQ_BREAK,  8'h00, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hF0, 1'b1, NO_REPORT},
    '{REQ_TXDONE, 8'h00, 1'b1, '{1'b0, 8'h00, ST_ERR, 8'hF0, 64'd0}},
    '{REQ_BREAK,  8'h00, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hF0, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'hFF, 1'b1, NO_REPORT},
    '{REQ_BYTE,   8'h00, 1'b0, NO_REPORT},
    '{REQ_TICK,   8'hFF, 1'b1, NO_REPORT}
  };

  localparam int PHASE_WORDS = 225;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [63:0]           cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [79:0]           m_tdata;
  logic [3:0]            m_tuser;

  // Frame engine as predicted: registers and sequencer state.
  cfg_t        lin_cfg;
  phase_t      lin_phase;
  logic [3:0]  lin_index;
  logic [7:0]  lin_pid;
  logic [7:0]  lin_store [8];
  logic [7:0]  lin_sum;
  logic [7:0]  lin_timer;

  lin_result_t lin_expected [$];
  lin_result_t got_word;
  lin_result_t want_word;
  int unsigned mismatch_count;
  int unsigned sent_words;
  int unsigned src_gap_pct;
  int unsigned stall_pct;

  lin_slave_frame_handler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // End-around add: a sum above 0xFF has 0xFF taken off.
  function automatic logic [7:0] lin_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t > 9'd255) t = t - 9'd255;
    return t[7:0];
  endfunction

  // Classic checksum for the two diagnostic PIDs, enhanced for the rest.
  function automatic logic [7:0] sum_seed(input logic [7:0] pid);
    return (pid == CLASSIC_PID_A || pid == CLASSIC_PID_B) ? 8'h00 : pid;
  endfunction

  function automatic logic [7:0] resp_byte(input logic [3:0] idx);
    return lin_cfg.response_data[idx[2:0]*8 +: 8];
  endfunction

  // Data length clamped to the range the data store supports.
  function automatic int unsigned frame_len();
    int unsigned n;
    n = lin_cfg.data_length;
    if (n < 1) n = 1;
    if (n > MAX_DATA_BYTES_DEF) n = MAX_DATA_BYTES_DEF;
    return n;
  endfunction

  task automatic reset_frame_model();
    lin_cfg.pid_receive   = 8'hF0;
    lin_cfg.pid_respond   = 8'hB1;
    lin_cfg.response_data = 64'h5F5E5D5C5B5A5958;
    lin_cfg.data_length   = 4'd8;
    lin_cfg.timeout_ticks = 8'd10;
    lin_cfg.sync_check    = 1'b0;
    lin_phase = PH_IDLE;
    lin_index = 4'd0;
    lin_pid   = 8'h00;
    lin_sum   = 8'h00;
    lin_timer = 8'h00;
    foreach (lin_store[i]) lin_store[i] = 8'h00;
  endtask

  // Advances the frame engine by one event and returns its result word.
  task automatic predict_frame_event(input logic [1:0] req, input logic [7:0] rx,
                                     output lin_result_t r);
    int unsigned len;
    logic [7:0]  s;
    r = NO_REPORT;
    len = frame_len();
    case (req)
      REQ_BREAK: begin
        lin_phase = lin_cfg.sync_check ? PH_SYNC : PH_PID;
        lin_pid   = 8'h00;
        lin_index = 4'd0;
        lin_timer = lin_cfg.timeout_ticks;
      end
      REQ_BYTE: begin
        case (lin_phase)
          PH_IDLE: begin
          end
          PH_SYNC: begin
            if (rx == SYNC_BYTE) begin
              lin_phase = PH_PID;
              lin_timer = lin_cfg.timeout_ticks;
            end else begin
              r.status = ST_ERR;
            end
          end
          PH_PID: begin
            lin_timer = lin_cfg.timeout_ticks;
            lin_pid   = rx;
            // The response PID wins when both registers hold the same value.
            if (rx == lin_cfg.pid_respond) begin
              s = sum_seed(rx);
              for (int i = 0; i < len; i++) s = lin_add(s, resp_byte(4'(i)));
              lin_sum    = s;
              r.tx_valid = 1'b1;
              r.tx_byte  = resp_byte(4'd0);
              lin_index  = 4'd1;
              lin_phase  = (len <= 1) ? PH_TXCHECK : PH_TXDATA;
            end else if (rx == lin_cfg.pid_receive) begin
              lin_sum   = sum_seed(rx);
              lin_index = 4'd0;
              lin_phase = PH_RXDATA;
            end else begin
              r.status = ST_ERR;
            end
          end
          PH_RXDATA: begin
            lin_timer = lin_cfg.timeout_ticks;
            lin_store[lin_index[2:0]] = rx;
            lin_sum   = lin_add(lin_sum, rx);
            lin_index = lin_index + 4'd1;
            if (lin_index >= len) lin_phase = PH_RXCHECK;
          end
          PH_RXCHECK: begin
            lin_timer = lin_cfg.timeout_ticks;
            for (int i = 0; i < len; i++) r.data[i*8 +: 8] = lin_store[i];
            r.status = (rx == ~lin_sum) ? ST_RXOK : ST_RXBAD;
          end
          default: r.status = ST_ERR;
        endcase
      end
      REQ_TXDONE: begin
        case (lin_phase)
          PH_IDLE: begin
          end
          PH_TXDATA: begin
            lin_timer  = lin_cfg.timeout_ticks;
            r.tx_valid = 1'b1;
            r.tx_byte  = resp_byte(lin_index);
            lin_index  = lin_index + 4'd1;
            if (lin_index >= len) lin_phase = PH_TXCHECK;
          end
          PH_TXCHECK: begin
            lin_timer  = lin_cfg.timeout_ticks;
            r.tx_valid = 1'b1;
            r.tx_byte  = ~lin_sum;
            r.status   = ST_SENT;
          end
          default: r.status = ST_ERR;
        endcase
      end
      default: begin
        // The tick counter holds at zero; a frame in progress times out there.
        if (lin_timer != 8'd0) lin_timer = lin_timer - 8'd1;
        if (lin_phase != PH_IDLE && lin_timer == 8'd0) r.status = ST_TIMEOUT;
      end
    endcase
    if (r.status != ST_NONE) begin
      lin_phase = PH_IDLE;
      lin_index = 4'd0;
    end
    if (r.tx_valid || r.status != ST_NONE) r.pid = lin_pid;
  endtask

  // Offers one event word, waits for it to be taken and records the prediction.
  task automatic send_event(input logic [1:0] req, input logic [7:0] rx);
    lin_result_t r;
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_frame_event(req, rx, r);
    lin_expected.push_back(r);
    sent_words++;
  endtask

  // Occasional ticks and stray events between the words of a frame.
  task automatic maybe_disturb();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_event(REQ_TICK, 8'($urandom));
    end else if (pick < 11) begin
      send_event(2'($urandom), 8'($urandom));
    end else if (pick < 12) begin
      repeat ($urandom_range(1, 12)) send_event(REQ_TICK, 8'($urandom));
    end
  endtask

  // One frame, mostly well formed, with random content.
  task automatic send_frame();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  pid;
    len = frame_len();
    if ($urandom_range(99) < 95) send_event(REQ_BREAK, 8'($urandom));
    maybe_disturb();
    if (lin_cfg.sync_check)
      send_event(REQ_BYTE, ($urandom_range(99) < 90) ? SYNC_BYTE : 8'($urandom));
    maybe_disturb();
    pick = $urandom_range(99);
    pid = (pick < 45) ? lin_cfg.pid_respond :
          (pick < 90) ? lin_cfg.pid_receive : 8'($urandom);
    send_event(REQ_BYTE, pid);
    if (pid == lin_cfg.pid_respond) begin
      for (int k = 0; k < len; k++) begin
        maybe_disturb();
        send_event(REQ_TXDONE, 8'($urandom));
      end
      // The done of the checksum byte may arrive once the frame is closed.
      if ($urandom_range(1) == 1) send_event(REQ_TXDONE, 8'($urandom));
    end else if (pid == lin_cfg.pid_receive) begin
      for (int k = 0; k < len; k++) begin
        maybe_disturb();
        send_event(REQ_BYTE, 8'($urandom));
      end
      maybe_disturb();
      send_event(REQ_BYTE, ($urandom_range(99) < 70) ? ~lin_sum : 8'($urandom));
    end
    maybe_disturb();
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      CFG_PID_RECEIVE:   lin_cfg.pid_receive   = value[7:0];
      CFG_PID_RESPOND:   lin_cfg.pid_respond   = value[7:0];
      CFG_RESPONSE_DATA: lin_cfg.response_data = value;
      CFG_DATA_LENGTH:   lin_cfg.data_length   = value[3:0];
      CFG_TIMEOUT_TICKS: lin_cfg.timeout_ticks = value[7:0];
      CFG_SYNC_CHECK:    lin_cfg.sync_check    = value[0];
      default: begin
      end
    endcase
  endtask

  // Register settings per phase; fixed ones cover reset values, extremes and equal PIDs.
  task automatic load_setting(input int p);
    logic [7:0]  prx;
    logic [7:0]  prs;
    logic [63:0] rdata;
    logic [3:0]  len;
    logic [7:0]  tmo;
    logic        sync;
    prx   = 8'($urandom);
    prs   = 8'($urandom);
    rdata = {$urandom, $urandom};
    len   = 4'($urandom_range(0, 15));
    tmo   = 8'($urandom_range(0, 255));
    sync  = 1'($urandom);
    case (p)
      0: begin prx = 8'hF0; prs = 8'hB1; len = 4'd8;  tmo = 8'd10;  sync = 1'b0; end
      1: begin prx = 8'h3C; prs = 8'h7D; len = 4'd1;  tmo = 8'd1;   sync = 1'b1; end
      2: begin prx = 8'h7D; prs = 8'h3C; len = 4'd15; tmo = 8'd255; sync = 1'b1; end
      3: begin prx = 8'h00; prs = 8'hFF; rdata = 64'd0; len = 4'd0; tmo = 8'd0; sync = 1'b0; end
      4: begin prx = 8'hAA; prs = 8'hAA; rdata = '1; len = 4'd4; tmo = 8'd3; sync = 1'b1; end
      6: begin prx = 8'hFF; prs = 8'h00; len = 4'd8;  tmo = 8'd2;   sync = 1'b0; end
      7: begin len = 4'($urandom_range(1, 3)); tmo = 8'($urandom_range(4, 20)); end
      default: begin
      end
    endcase
    write_reg(CFG_PID_RECEIVE,   {56'd0, prx});
    write_reg(CFG_PID_RESPOND,   {56'd0, prs});
    write_reg(CFG_RESPONSE_DATA, rdata);
    write_reg(CFG_DATA_LENGTH,   {60'd0, len});
    write_reg(CFG_TIMEOUT_TICKS, {56'd0, tmo});
    write_reg(CFG_SYNC_CHECK,    {63'd0, sync});
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (lin_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  // Output side: random stalls at the rate of the current phase.
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word.tx_valid = m_tuser[0];
      got_word.status   = m_tuser[3:1];
      got_word.tx_byte  = m_tdata[7:0];
      got_word.pid      = m_tdata[15:8];
      got_word.data     = m_tdata[79:16];
      if (lin_expected.size() == 0) begin
        flag_mismatch("word with nothing pending", 64'd0, {48'd0, m_tdata[15:0]});
      end else begin
        want_word = lin_expected.pop_front();
        if (got_word.tx_valid != want_word.tx_valid)
          flag_mismatch("tx_valid", want_word.tx_valid, got_word.tx_valid);
        if (got_word.tx_byte != want_word.tx_byte)
          flag_mismatch("tx_byte", want_word.tx_byte, got_word.tx_byte);
        if (got_word.status != want_word.status)
          flag_mismatch("frame_status", want_word.status, got_word.status);
        if (got_word.pid != want_word.pid)
          flag_mismatch("frame_pid", want_word.pid, got_word.pid);
        if (got_word.data != want_word.data)
          flag_mismatch("frame_data", want_word.data, got_word.data);
      end
    end
  end

  // Main sequence: reset, directed rows, then random frames per setting.
  initial begin
    int unsigned start_words;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = 64'd0;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    s_tuser        = REQ_BREAK;
    m_tready       = 1'b0;
    mismatch_count = 0;
    sent_words     = 0;
    src_gap_pct    = 0;
    stall_pct      = 0;
    reset_frame_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rows with a typed result replace the prediction just queued.
    foreach (STIM_ROWS[k]) begin
      send_event(STIM_ROWS[k].req, STIM_ROWS[k].rx);
      if (STIM_ROWS[k].typed) lin_expected[lin_expected.size() - 1] = STIM_ROWS[k].res;
    end

    for (int p = 0; p < 8; p++) begin
      // A break followed by a transmit done always leaves the engine idle.
      send_event(REQ_BREAK, 8'($urandom));
      send_event(REQ_TXDONE, 8'($urandom));
      wait_drained();
      load_setting(p);
      case (p % 4)
        0: begin src_gap_pct = 0;  stall_pct = 0;  end
        1: begin src_gap_pct = 72; stall_pct = 0;  end
        2: begin src_gap_pct = 0;  stall_pct = 72; end
        default: begin src_gap_pct = 24; stall_pct = 24; end
      endcase
      start_words = sent_words;
      while (sent_words - start_words < PHASE_WORDS) send_frame();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
